>>> hdl/rarp_pkg.sv
// shared types and constants for the array request parser
package rarp_pkg;

  // default bounds of the element count and element length
  localparam int unsigned DEF_COUNT_BITS  = 16;
  localparam int unsigned DEF_LENGTH_BITS = 32;

  // width of the element index field
  localparam int unsigned INDEX_BITS = 16;

  // characters of the wire format
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_EMPTY_EL  = 2'd1,
    KIND_EMPTY_MSG = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  // parser phases
  typedef enum logic [3:0] {
    PH_MARK      = 4'd0,
    PH_CNT_FIRST = 4'd1,
    PH_CNT       = 4'd2,
    PH_CNT_LF    = 4'd3,
    PH_EL_MARK   = 4'd4,
    PH_LEN       = 4'd5,
    PH_LEN_LF    = 4'd6,
    PH_PAYLOAD   = 4'd7,
    PH_TRAIL1    = 4'd8,
    PH_TRAIL2    = 4'd9,
    PH_WAIT      = 4'd10
  } phase_e;

endpackage

>>> hdl/rarp_if.sv
// request byte channel and result channel interfaces
interface rarp_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink (input valid, input data_byte, input start_req, output ready);
endinterface

interface rarp_rsp_if;
  logic                                valid;
  logic                                ready;
  rarp_pkg::kind_e                     kind;
  logic [7:0]                          payload_byte;
  logic [rarp_pkg::INDEX_BITS-1:0]     element_index;
  logic                                first_of_element;
  logic                                last_of_element;
  logic                                last_of_message;

  modport source (output valid, output kind, output payload_byte, output element_index,
                  output first_of_element, output last_of_element,
                  output last_of_message, input ready);
  modport sink (input valid, input kind, input payload_byte, input element_index,
                input first_of_element, input last_of_element,
                input last_of_message, output ready);
endinterface

>>> hdl/resp_array_request_parser.sv
// Parses an array of bulk strings one byte per cycle. A byte enters an input
// register, the next parser state and the result are formed from it
// combinationally, and a result lands in an output register: throughput is
// one byte per clock while the result side keeps up, and a result is offered
// on the result channel from the output register. A result left waiting on the
// result channel holds up every following byte, also those that give no result.
// Only bytes that produce a result (payload bytes, empty markers, errors)
// show up on the result channel; all other bytes just advance the state.
// After a format error the parser drops bytes until start_req is set.
module resp_array_request_parser #(
  parameter int unsigned COUNT_BITS  = rarp_pkg::DEF_COUNT_BITS,
  parameter int unsigned LENGTH_BITS = rarp_pkg::DEF_LENGTH_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rarp_req_if.sink   req_i,
  rarp_rsp_if.source rsp_o
);

  localparam int unsigned ACC_BITS = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
  localparam int unsigned MUL_BITS = ACC_BITS + 4;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;
  logic       step;
  logic       out_free;

  // parser state
  rarp_pkg::phase_e       phase_q, phase_d;
  logic [ACC_BITS-1:0]    acc_q, acc_d;
  logic [COUNT_BITS-1:0]  left_q, left_d;
  logic [COUNT_BITS-1:0]  cur_q, cur_d;
  logic [LENGTH_BITS-1:0] pay_q, pay_d;
  logic                   neg_q, neg_d;

  // result of this step
  logic                           res_valid;
  rarp_pkg::kind_e                res_kind;
  logic [7:0]                     res_byte;
  logic [rarp_pkg::INDEX_BITS-1:0] res_index;
  logic                           res_first;
  logic                           res_last;
  logic                           res_last_msg;

  // output register
  logic                           out_valid_q;
  rarp_pkg::kind_e                out_kind_q;
  logic [7:0]                     out_byte_q;
  logic [rarp_pkg::INDEX_BITS-1:0] out_index_q;
  logic                           out_first_q;
  logic                           out_last_q;
  logic                           out_last_msg_q;

  // decimal accumulate
  logic                is_digit;
  logic [3:0]          digit_val;
  logic [MUL_BITS-1:0] acc_wide;
  logic [MUL_BITS-1:0] acc_ten;
  logic                cnt_over;
  logic                len_over;
  logic                last_byte;
  logic                last_elem;

  // handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign step        = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_byte_q  <= req_i.data_byte;
      in_start_q <= req_i.start_req;
    end
  end

  // accumulator times ten plus digit, with room to spot overflow
  assign is_digit  = (in_byte_q >= rarp_pkg::CHAR_ZERO) && (in_byte_q <= rarp_pkg::CHAR_NINE);
  assign digit_val = 4'(in_byte_q - rarp_pkg::CHAR_ZERO);
  assign acc_wide  = MUL_BITS'(acc_q);
  assign acc_ten   = (acc_wide << 3) + (acc_wide << 1) + MUL_BITS'(digit_val);
  assign cnt_over  = |acc_ten[MUL_BITS-1:COUNT_BITS];
  assign len_over  = |acc_ten[MUL_BITS-1:LENGTH_BITS];
  assign last_byte = (pay_q <= LENGTH_BITS'(1));
  assign last_elem = (left_q == COUNT_BITS'(1));

  // next state and result
  always_comb begin
    phase_d      = phase_q;
    acc_d        = acc_q;
    left_d       = left_q;
    cur_d        = cur_q;
    pay_d        = pay_q;
    neg_d        = neg_q;
    res_valid    = 1'b0;
    res_kind     = rarp_pkg::KIND_BYTE;
    res_byte     = 8'd0;
    res_index    = rarp_pkg::INDEX_BITS'(cur_q);
    res_first    = 1'b0;
    res_last     = 1'b0;
    res_last_msg = 1'b0;

    if (in_start_q || phase_q == rarp_pkg::PH_MARK) begin
      phase_d = rarp_pkg::PH_CNT_FIRST;
      acc_d   = '0;
      left_d  = '0;
      cur_d   = '0;
      pay_d   = '0;
      neg_d   = 1'b0;
    end else begin
      case (phase_q)
        rarp_pkg::PH_CNT_FIRST, rarp_pkg::PH_CNT: begin
          if (phase_q == rarp_pkg::PH_CNT_FIRST && in_byte_q == rarp_pkg::CHAR_MINUS) begin
            neg_d   = 1'b1;
            phase_d = rarp_pkg::PH_CNT;
          end else if (is_digit) begin
            if (cnt_over) begin
              phase_d   = rarp_pkg::PH_WAIT;
              res_valid = 1'b1;
              res_kind  = rarp_pkg::KIND_ERROR;
            end else begin
              acc_d   = acc_ten[ACC_BITS-1:0];
              phase_d = rarp_pkg::PH_CNT;
            end
          end else if (in_byte_q == rarp_pkg::CHAR_CR) begin
            phase_d = rarp_pkg::PH_CNT_LF;
          end else begin
            phase_d   = rarp_pkg::PH_WAIT;
            res_valid = 1'b1;
            res_kind  = rarp_pkg::KIND_ERROR;
          end
        end
        rarp_pkg::PH_CNT_LF: begin
          if (in_byte_q != rarp_pkg::CHAR_LF) begin
            phase_d   = rarp_pkg::PH_WAIT;
            res_valid = 1'b1;
            res_kind  = rarp_pkg::KIND_ERROR;
          end else if (neg_q || acc_q == '0) begin
            // nothing to parse: one empty message marker
            phase_d      = rarp_pkg::PH_MARK;
            acc_d        = '0;
            res_valid    = 1'b1;
            res_kind     = rarp_pkg::KIND_EMPTY_MSG;
            res_index    = '0;
            res_last_msg = 1'b1;
          end else begin
            left_d  = acc_q[COUNT_BITS-1:0];
            cur_d   = '0;
            acc_d   = '0;
            phase_d = rarp_pkg::PH_EL_MARK;
          end
        end
        rarp_pkg::PH_EL_MARK: begin
          acc_d   = '0;
          phase_d = rarp_pkg::PH_LEN;
        end
        rarp_pkg::PH_LEN: begin
          if (is_digit) begin
            if (len_over) begin
              phase_d   = rarp_pkg::PH_WAIT;
              res_valid = 1'b1;
              res_kind  = rarp_pkg::KIND_ERROR;
            end else begin
              acc_d = acc_ten[ACC_BITS-1:0];
            end
          end else if (in_byte_q == rarp_pkg::CHAR_CR) begin
            phase_d = rarp_pkg::PH_LEN_LF;
          end else begin
            phase_d   = rarp_pkg::PH_WAIT;
            res_valid = 1'b1;
            res_kind  = rarp_pkg::KIND_ERROR;
          end
        end
        rarp_pkg::PH_LEN_LF: begin
          if (in_byte_q != rarp_pkg::CHAR_LF) begin
            phase_d   = rarp_pkg::PH_WAIT;
            res_valid = 1'b1;
            res_kind  = rarp_pkg::KIND_ERROR;
          end else if (acc_q == '0) begin
            // empty element still has its trailer to skip
            phase_d      = rarp_pkg::PH_TRAIL1;
            res_valid    = 1'b1;
            res_kind     = rarp_pkg::KIND_EMPTY_EL;
            res_last     = 1'b1;
            res_last_msg = last_elem;
          end else begin
            pay_d   = acc_q[LENGTH_BITS-1:0];
            phase_d = rarp_pkg::PH_PAYLOAD;
          end
        end
        rarp_pkg::PH_PAYLOAD: begin
          res_valid    = 1'b1;
          res_kind     = rarp_pkg::KIND_BYTE;
          res_byte     = in_byte_q;
          res_first    = (pay_q == acc_q[LENGTH_BITS-1:0]);
          res_last     = last_byte;
          res_last_msg = last_byte && last_elem;
          pay_d        = (pay_q != '0) ? pay_q - LENGTH_BITS'(1) : '0;
          if (last_byte) begin
            phase_d = rarp_pkg::PH_TRAIL1;
          end
        end
        rarp_pkg::PH_TRAIL1: begin
          phase_d = rarp_pkg::PH_TRAIL2;
        end
        rarp_pkg::PH_TRAIL2: begin
          left_d  = (left_q != '0) ? left_q - COUNT_BITS'(1) : '0;
          cur_d   = cur_q + COUNT_BITS'(1);
          acc_d   = '0;
          phase_d = (left_q <= COUNT_BITS'(1)) ? rarp_pkg::PH_MARK : rarp_pkg::PH_EL_MARK;
        end
        default: begin
          // waiting for a start request
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rarp_pkg::PH_MARK;
      acc_q   <= '0;
      left_q  <= '0;
      cur_q   <= '0;
      pay_q   <= '0;
      neg_q   <= 1'b0;
    end else if (step) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      cur_q   <= cur_d;
      pay_q   <= pay_d;
      neg_q   <= neg_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_kind_q     <= res_kind;
      out_byte_q     <= res_byte;
      out_index_q    <= res_index;
      out_first_q    <= res_first;
      out_last_q     <= res_last;
      out_last_msg_q <= res_last_msg;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.kind             = out_kind_q;
  assign rsp_o.payload_byte     = out_byte_q;
  assign rsp_o.element_index    = out_index_q;
  assign rsp_o.first_of_element = out_first_q;
  assign rsp_o.last_of_element  = out_last_q;
  assign rsp_o.last_of_message  = out_last_msg_q;

  // an error transaction always leaves the parser waiting for start
  a_err_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_valid && res_kind == rarp_pkg::KIND_ERROR |=> phase_q == rarp_pkg::PH_WAIT)
    else $error("error result did not park the parser");

  // payload phase never runs with nothing left to stream
  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == rarp_pkg::PH_PAYLOAD |-> pay_q != '0)
    else $error("payload phase with zero bytes left");

  // element phases always have at least one element outstanding
  a_elem_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == rarp_pkg::PH_EL_MARK || phase_q == rarp_pkg::PH_LEN ||
     phase_q == rarp_pkg::PH_LEN_LF || phase_q == rarp_pkg::PH_PAYLOAD ||
     phase_q == rarp_pkg::PH_TRAIL1 || phase_q == rarp_pkg::PH_TRAIL2) |-> left_q != '0)
    else $error("element phase with no elements left");

  // a held input byte is not lost while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input byte dropped");

  // a message end on a payload byte is also an element end
  a_msg_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == rarp_pkg::KIND_BYTE && out_last_msg_q |-> out_last_q)
    else $error("message end without element end");

endmodule
